>>> rtl/msf_pkg.sv
package msf_pkg;

    localparam int DATA_W    = 32;
    localparam int LEN_W     = 7;
    localparam int M_TDATA_W = 40;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic srch_cmp;
        logic write;
        logic scan_step;
        logic pred_write;
        logic emit_init;
        logic chain_sel;
        logic chain_step;
        logic out_load;
        logic clear;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic srch_more;
        logic lo_zero;
        logic cnt_zero;
        logic scan_hit;
        logic scan_empty;
        logic chain_more;
        logic out_taken;
        logic out_final;
    } sts_t;

endpackage

>>> rtl/msf_dp.sv
module msf_dp #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic [msf_pkg::DATA_W-1:0]      in_value,
    input  msf_pkg::cmd_t                   cmd,
    output msf_pkg::sts_t                   sts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [msf_pkg::DATA_W-1:0]      out_element,
    output logic [msf_pkg::LEN_W-1:0]       out_length,
    output logic                            out_final,
    output logic                            out_overflow
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int DW = msf_pkg::DATA_W;
    localparam int LW = msf_pkg::LEN_W;

    // strictly before in the chosen order
    function automatic logic ahead(input logic dec, input logic [DW-1:0] a,
                                   input logic [DW-1:0] b);
        logic lt;
        logic gt;
        lt = $signed(a) < $signed(b);
        gt = $signed(a) > $signed(b);
        return dec ? gt : lt;
    endfunction

    logic [DW-1:0] tails_mem [MAX_ELEMENTS];
    logic [DW-1:0] sv_mem    [MAX_ELEMENTS];
    logic [AW-1:0] tp_mem    [MAX_ELEMENTS];
    logic [AW:0]   pred_mem  [MAX_ELEMENTS];   // MSB set: no predecessor
    logic [DW-1:0] rev_mem   [MAX_ELEMENTS];

    logic [DW-1:0] tails_rd_reg;
    logic [DW-1:0] sv_rd_reg;
    logic [AW-1:0] tp_rd_reg;
    logic [AW:0]   pred_rd_reg;
    logic [DW-1:0] rev_rd_reg;

    logic          mode_reg;
    logic [DW-1:0] x_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] elem_reg;
    logic          ovf_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hi_reg;
    logic [AW-1:0] scan_addr_reg;
    logic          scan_more_reg;
    logic [AW-1:0] chk_addr_reg;
    logic          chk_v_reg;
    logic [AW-1:0] tgt_reg;
    logic          kind_acc_reg;
    logic [AW-1:0] cur_reg;
    logic          found_v_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] k_reg;
    logic          out_valid_reg;
    logic [DW-1:0] out_elem_reg;
    logic [LW-1:0] out_len_reg;
    logic          out_final_reg;
    logic          out_ovf_reg;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [AW-1:0] sv_addr;
    logic [AW-1:0] i_addr;
    logic [CW-1:0] lo_m1;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] elem_m1;
    logic [CW-1:0] n_p1;
    logic [CW-1:0] n_m1;
    logic [CW-1:0] rev_idx;
    logic          hit;
    logic          taken;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CW:1];
    assign sv_addr = cmd.chain_sel ? cur_reg : scan_addr_reg;
    assign i_addr  = elem_reg[AW-1:0];
    assign lo_m1   = lo_reg - 1'b1;
    assign cnt_m1  = cnt_reg - 1'b1;
    assign elem_m1 = elem_reg - 1'b1;
    assign n_p1    = n_reg + 1'b1;
    assign n_m1    = n_reg - 1'b1;
    assign rev_idx = n_m1 - k_reg;
    assign taken   = out_valid_reg && out_ready;

    assign hit = chk_v_reg && (tp_rd_reg == tgt_reg)
               && (!kind_acc_reg || ahead(mode_reg, sv_rd_reg, x_reg));

    always_comb
    begin
        sts            = '0;
        sts.full       = (elem_reg == CW'(MAX_ELEMENTS));
        sts.srch_more  = (lo_reg < hi_reg);
        sts.lo_zero    = (lo_reg == '0);
        sts.cnt_zero   = (cnt_reg == '0);
        sts.scan_hit   = hit;
        sts.scan_empty = !scan_more_reg && !chk_v_reg;
        sts.chain_more = !pred_rd_reg[AW] && (n_p1 < cnt_reg);
        sts.out_taken  = taken;
        sts.out_final  = (k_reg == n_m1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            cnt_reg       <= '0;
            elem_reg      <= '0;
            ovf_reg       <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            scan_addr_reg <= '0;
            scan_more_reg <= 1'b0;
            chk_addr_reg  <= '0;
            chk_v_reg     <= 1'b0;
            tgt_reg       <= '0;
            kind_acc_reg  <= 1'b0;
            cur_reg       <= '0;
            found_v_reg   <= 1'b0;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (cmd.capture)
            begin
                lo_reg <= '0;
                hi_reg <= cnt_reg;
                if (sts.full)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.srch_cmp)
            begin
                if (ahead(mode_reg, tails_rd_reg, x_reg))
                begin
                    lo_reg <= mid + 1'b1;
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            if (cmd.write)
            begin
                if (lo_reg == cnt_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                // parent scan walks back from the newest stored element
                found_v_reg   <= 1'b0;
                scan_addr_reg <= elem_m1[AW-1:0];
                scan_more_reg <= 1'b1;
                chk_v_reg     <= 1'b0;
                tgt_reg       <= lo_m1[AW-1:0];
                kind_acc_reg  <= 1'b1;
            end
            if (cmd.emit_init)
            begin
                found_v_reg   <= 1'b0;
                scan_addr_reg <= elem_m1[AW-1:0];
                scan_more_reg <= 1'b1;
                chk_v_reg     <= 1'b0;
                tgt_reg       <= cnt_m1[AW-1:0];
                kind_acc_reg  <= 1'b0;
                n_reg         <= '0;
                k_reg         <= '0;
            end
            if (cmd.scan_step)
            begin
                // one read issued and one compare done per cycle
                if (scan_more_reg)
                begin
                    chk_addr_reg  <= scan_addr_reg;
                    chk_v_reg     <= 1'b1;
                    scan_addr_reg <= scan_addr_reg - 1'b1;
                    scan_more_reg <= (scan_addr_reg != '0);
                end
                else
                begin
                    chk_v_reg <= 1'b0;
                end
                if (hit)
                begin
                    cur_reg     <= chk_addr_reg;
                    found_v_reg <= 1'b1;
                end
            end
            if (cmd.pred_write)
            begin
                elem_reg <= elem_reg + 1'b1;
            end
            if (cmd.chain_step)
            begin
                n_reg   <= n_p1;
                cur_reg <= pred_rd_reg[AW-1:0];
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            if (taken)
            begin
                out_valid_reg <= 1'b0;
                k_reg         <= k_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                cnt_reg  <= '0;
                elem_reg <= '0;
                ovf_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tails_rd_reg <= tails_mem[mid[AW-1:0]];
        sv_rd_reg    <= sv_mem[sv_addr];
        tp_rd_reg    <= tp_mem[scan_addr_reg];
        pred_rd_reg  <= pred_mem[cur_reg];
        rev_rd_reg   <= rev_mem[rev_idx[AW-1:0]];
        if (cmd.write)
        begin
            tails_mem[lo_reg[AW-1:0]] <= x_reg;
            sv_mem[i_addr]            <= x_reg;
            tp_mem[i_addr]            <= lo_reg[AW-1:0];
        end
        if (cmd.pred_write)
        begin
            pred_mem[i_addr] <= found_v_reg ? {1'b0, cur_reg} : {1'b1, {AW{1'b0}}};
        end
        if (cmd.chain_step)
        begin
            rev_mem[n_reg[AW-1:0]] <= sv_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg <= in_value;
        end
        if (cmd.out_load)
        begin
            out_elem_reg  <= rev_rd_reg;
            out_len_reg   <= LW'(n_reg);
            out_final_reg <= sts.out_final;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_element  = out_elem_reg;
    assign out_length   = out_len_reg;
    assign out_final    = out_final_reg;
    assign out_overflow = out_ovf_reg;

endmodule

>>> rtl/msf_ctrl.sv
module msf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_last,
    output logic          in_ready,
    input  msf_pkg::sts_t sts,
    output msf_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_CHK,
        ST_SRCH_CMP,
        ST_WRITE,
        ST_SCAN_ACC,
        ST_PRED_WR,
        ST_EMIT_INIT,
        ST_SCAN_EMIT,
        ST_CHAIN_RD,
        ST_CHAIN_WR,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   last_reg;
    logic   last_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    last_next   = in_last;
                    if (sts.full)
                    begin
                        state_next = in_last ? ST_EMIT_INIT : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SRCH_CHK;
                    end
                end
            end
            ST_SRCH_CHK:
            begin
                state_next = sts.srch_more ? ST_SRCH_CMP : ST_WRITE;
            end
            ST_SRCH_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = ST_SRCH_CHK;
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = sts.lo_zero ? ST_PRED_WR : ST_SCAN_ACC;
            end
            ST_SCAN_ACC:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit || sts.scan_empty)
                begin
                    state_next = ST_PRED_WR;
                end
            end
            ST_PRED_WR:
            begin
                cmd.pred_write = 1'b1;
                state_next     = last_reg ? ST_EMIT_INIT : ST_IDLE;
            end
            ST_EMIT_INIT:
            begin
                cmd.emit_init = 1'b1;
                state_next    = sts.cnt_zero ? ST_FINISH : ST_SCAN_EMIT;
            end
            ST_SCAN_EMIT:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = ST_CHAIN_RD;
                end
                else if (sts.scan_empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CHAIN_RD:
            begin
                cmd.chain_sel = 1'b1;
                state_next    = ST_CHAIN_WR;
            end
            ST_CHAIN_WR:
            begin
                cmd.chain_step = 1'b1;
                state_next     = sts.chain_more ? ST_CHAIN_RD : ST_OUT_RD;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (sts.out_taken)
                begin
                    state_next = sts.out_final ? ST_FINISH : ST_OUT_RD;
                end
            end
            ST_FINISH:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

>>> rtl/monotone_subsequence_finder.sv
// Longest strictly monotone subsequence of a stream of signed 32-bit values.
// Input: one value per s_axis beat, s_axis_tlast on the last value of a sequence.
// Output: on the last input beat the subsequence is sent on m_axis in sequence
// order, one element per beat, m_axis_tlast on its final element; every beat
// also carries the subsequence length and the overflow flag (values dropped
// because MAX_ELEMENTS were already stored in this sequence).
// cfg_wr_en/cfg_wr_data set the order: 0 increasing, 1 decreasing.
// The block takes one item at a time. An item that is stored does a binary
// search over the tails memory (one registered read per probe), then a
// backward parent scan over the stored values (1 element per cycle).
// A dropped item is not searched or stored. After the last item the emit
// phase scans back for the last element of the subsequence, follows the
// parent chain into the reversal memory, then reads each element and loads
// it into the output register after the previous beat is taken. A stalled
// receiver holds the output register and the block takes no input until the
// whole subsequence has gone out.
// Reset clears the sequence state and sets increasing order; no clearing pass.
module monotone_subsequence_finder #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,     // order_mode
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [msf_pkg::DATA_W-1:0]        s_axis_tdata,    // [31:0] value
    input  logic                              s_axis_tlast,    // end_of_sequence
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] element, [38:32] subsequence_length, [39] zero
    output logic [msf_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast,    // final_element
    output logic [0:0]                        m_axis_tuser     // [0] overflow
);

    msf_pkg::cmd_t                  cmd;
    msf_pkg::sts_t                  sts;
    logic [msf_pkg::DATA_W-1:0]     out_element;
    logic [msf_pkg::LEN_W-1:0]      out_length;
    logic                           out_overflow;

    msf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    msf_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_value     (s_axis_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_element  (out_element),
        .out_length   (out_length),
        .out_final    (m_axis_tlast),
        .out_overflow (out_overflow)
    );

    assign m_axis_tdata = {1'b0, out_length, out_element};
    assign m_axis_tuser = out_overflow;

endmodule

>>> rtl/msf_checker.sv
module msf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed under stall");

    // no input is taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while output pending");

    // the block stays busy between beats of one subsequence
    a_busy_midframe: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
        else $error("input ready before subsequence finished");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[38:32] != 7'd0) && (m_axis_tdata[39] == 1'b0))
        else $error("bad subsequence length on output");

endmodule

bind monotone_subsequence_finder msf_checker u_msf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
